// File: sv/fra_pkg.sv
// ----------------------------------------------------------------------------
// Fraction arithmetic package
// Shared codes, sequencer states and the request/response structs of the
// shared divider.
// ----------------------------------------------------------------------------
`default_nettype none

package fra_pkg;

	// Operation codes carried in tuser of the input beat.
	localparam logic [1:0] KIND_ADD = 2'd0;
	localparam logic [1:0] KIND_SUB = 2'd1;
	localparam logic [1:0] KIND_MUL = 2'd2;
	localparam logic [1:0] KIND_DIV = 2'd3;

	// Status codes carried in tuser of the output beat.
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_ZERO_DEN = 2'd1;
	localparam logic [1:0] STATUS_DIV_ZERO = 2'd2;

	// Widths of the divider operands.
	localparam int unsigned DIVIDEND_W = 32;
	localparam int unsigned DIVISOR_W  = 31;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL0,
		ST_MUL1,
		ST_MUL2,
		ST_COMB,
		ST_CHECK,
		ST_WHOLE,
		ST_GCD,
		ST_NUM,
		ST_DEN,
		ST_DONE
	} state_t;

	// Request to the shared divider.
	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [DIVISOR_W-1:0]  divisor;
	} div_req_t;

	// Response of the shared divider; quotient and remainder hold while done.
	typedef struct packed {
		logic                  done;
		logic [DIVIDEND_W-1:0] quotient;
		logic [DIVIDEND_W-1:0] remainder;
	} div_rsp_t;

endpackage

`default_nettype wire

// File: sv/fra_div.sv
// ----------------------------------------------------------------------------
// Shared restoring divider
// Unsigned 32-bit by 31-bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fra_div (
	input  wire             clk,
	input  wire             arst_n,
	input  wire fra_pkg::div_req_t req,
	output fra_pkg::div_rsp_t rsp
);

	localparam int unsigned CNT_W = $clog2(fra_pkg::DIVIDEND_W);

	logic                            busy_q;
	logic                            done_q;
	logic [CNT_W-1:0]                cnt_q;
	logic [fra_pkg::DIVIDEND_W-1:0]  quo_q;
	logic [fra_pkg::DIVIDEND_W-1:0]  rem_q;
	logic [fra_pkg::DIVISOR_W-1:0]   dsr_q;
	logic [fra_pkg::DIVIDEND_W:0]    shifted;
	logic [fra_pkg::DIVIDEND_W:0]    diff;

	// One trial subtraction per cycle.
	assign shifted = {rem_q, quo_q[fra_pkg::DIVIDEND_W-1]};
	assign diff    = shifted - {2'b00, dsr_q};

	// Control: busy for one pass over the dividend bits, then a done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(fra_pkg::DIVIDEND_W - 1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(fra_pkg::DIVIDEND_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath: partial remainder and quotient shift together.
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			if (!diff[fra_pkg::DIVIDEND_W]) begin
				rem_q <= diff[fra_pkg::DIVIDEND_W-1:0];
				quo_q <= {quo_q[fra_pkg::DIVIDEND_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[fra_pkg::DIVIDEND_W-1:0];
				quo_q <= {quo_q[fra_pkg::DIVIDEND_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

`default_nettype wire

// File: sv/fraction_arith_reduce.sv
// ----------------------------------------------------------------------------
// Fraction arithmetic with reduction
// Adds, subtracts, multiplies or divides two signed 16-bit fractions, splits
// the magnitude into a whole part and a proper fraction, and reduces that
// fraction by its GCD found with the Euclid remainder loop.
//
//   Channel | Dir | tdata (low bit up)                          | tuser
//   s_axis  | in  | num_a, den_a, num_b, den_b (64 bits)        | kind (2)
//   m_axis  | out | negative, whole_part, frac_num, frac_den,   | status (2)
//           |     | two zero pad bits (96 bits)                 |
//
// An item with a zero denominator or a division by a zero fraction goes from
// accept straight to the result, and a zero result skips the divider. A full
// item uses the shared divider for the whole part, for each Euclid step and
// for the reduced numerator and denominator, so the one-bit-per-cycle shared
// divider sets its time.
// The input is ready only when idle.
// The result holds on m_axis until taken; reset clears the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module fraction_arith_reduce (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [63:0] s_axis_tdata,  // num_a, den_a, num_b, den_b
	input  wire  [1:0]  s_axis_tuser,  // kind
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [95:0] m_axis_tdata,  // negative, whole_part, frac_num, frac_den, pad
	output logic [1:0]  m_axis_tuser   // status
);

	fra_pkg::state_t   state_q, state_d;
	fra_pkg::div_req_t div_req;
	fra_pkg::div_rsp_t div_rsp;

	logic [1:0]         kind_q;
	logic signed [15:0] na_q, da_q, nb_q, db_q;
	logic signed [31:0] p0_q, p1_q, p2_q;
	logic signed [15:0] mul_a, mul_b;
	logic signed [31:0] mul_p;
	logic signed [32:0] top_c, abs_top;
	logic signed [31:0] bot_c, abs_bot;
	logic [31:0]        mag_top_q;
	logic [30:0]        mag_bot_q;
	logic [30:0]        y_q, g_q, frem_q;
	logic [30:0]        t_c;
	logic               err_den, err_div;
	logic [1:0]         status_q;
	logic               neg_q;
	logic [31:0]        whole_q;
	logic [29:0]        fnum_q;
	logic [30:0]        fden_q;

	fra_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Input checks on the incoming beat.
	assign err_den = (s_axis_tdata[31:16] == 16'd0) || (s_axis_tdata[63:48] == 16'd0);
	assign err_div = (s_axis_tuser == fra_pkg::KIND_DIV) && (s_axis_tdata[47:32] == 16'd0);

	// Shared multiplier operand selection per product step.
	always_comb begin
		mul_a = na_q;
		mul_b = db_q;
		case (state_q)
			fra_pkg::ST_MUL0: begin
				mul_a = na_q;
				mul_b = (kind_q == fra_pkg::KIND_MUL) ? nb_q : db_q;
			end
			fra_pkg::ST_MUL1: begin
				mul_a = (kind_q == fra_pkg::KIND_MUL) ? db_q : nb_q;
				mul_b = da_q;
			end
			default: begin
				mul_a = da_q;
				mul_b = db_q;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// Combine the products into one signed fraction and take magnitudes.
	always_comb begin
		case (kind_q)
			fra_pkg::KIND_ADD: top_c = {p0_q[31], p0_q} + {p1_q[31], p1_q};
			fra_pkg::KIND_SUB: top_c = {p0_q[31], p0_q} - {p1_q[31], p1_q};
			default:           top_c = {p0_q[31], p0_q};
		endcase
		bot_c   = (kind_q == fra_pkg::KIND_ADD || kind_q == fra_pkg::KIND_SUB) ? p2_q : p1_q;
		abs_top = top_c[32] ? -top_c : top_c;
		abs_bot = bot_c[31] ? -bot_c : bot_c;
	end

	assign t_c = div_rsp.remainder[30:0];

	// Sequencer: next state and divider requests.
	always_comb begin
		state_d          = state_q;
		div_req.start    = 1'b0;
		div_req.dividend = mag_top_q;
		div_req.divisor  = mag_bot_q;
		case (state_q)
			fra_pkg::ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = (err_den || err_div) ? fra_pkg::ST_DONE : fra_pkg::ST_MUL0;
				end
			end
			fra_pkg::ST_MUL0: state_d = fra_pkg::ST_MUL1;
			fra_pkg::ST_MUL1: state_d = fra_pkg::ST_MUL2;
			fra_pkg::ST_MUL2: state_d = fra_pkg::ST_COMB;
			fra_pkg::ST_COMB: state_d = fra_pkg::ST_CHECK;
			fra_pkg::ST_CHECK: begin
				if (mag_top_q == 32'd0) begin
					state_d = fra_pkg::ST_DONE;
				end else begin
					div_req.start = 1'b1;
					state_d       = fra_pkg::ST_WHOLE;
				end
			end
			fra_pkg::ST_WHOLE: begin
				if (div_rsp.done) begin
					if (div_rsp.remainder == 32'd0) begin
						state_d = fra_pkg::ST_DONE;
					end else begin
						div_req.start    = 1'b1;
						div_req.dividend = {1'b0, mag_bot_q};
						div_req.divisor  = t_c;
						state_d          = fra_pkg::ST_GCD;
					end
				end
			end
			fra_pkg::ST_GCD: begin
				if (div_rsp.done) begin
					div_req.start = 1'b1;
					if (t_c == 31'd0) begin
						div_req.dividend = {1'b0, frem_q};
						div_req.divisor  = y_q;
						state_d          = fra_pkg::ST_NUM;
					end else begin
						div_req.dividend = {1'b0, y_q};
						div_req.divisor  = t_c;
					end
				end
			end
			fra_pkg::ST_NUM: begin
				if (div_rsp.done) begin
					div_req.start    = 1'b1;
					div_req.dividend = {1'b0, mag_bot_q};
					div_req.divisor  = g_q;
					state_d          = fra_pkg::ST_DEN;
				end
			end
			fra_pkg::ST_DEN: begin
				if (div_rsp.done) begin
					state_d = fra_pkg::ST_DONE;
				end
			end
			fra_pkg::ST_DONE: begin
				if (m_axis_tready) begin
					state_d = fra_pkg::ST_IDLE;
				end
			end
			default: state_d = fra_pkg::ST_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fra_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			fra_pkg::ST_IDLE: begin
				kind_q   <= s_axis_tuser;
				na_q     <= s_axis_tdata[15:0];
				da_q     <= s_axis_tdata[31:16];
				nb_q     <= s_axis_tdata[47:32];
				db_q     <= s_axis_tdata[63:48];
				status_q <= err_den ? fra_pkg::STATUS_ZERO_DEN :
				            err_div ? fra_pkg::STATUS_DIV_ZERO : fra_pkg::STATUS_OK;
				neg_q    <= 1'b0;
				whole_q  <= '0;
				fnum_q   <= '0;
				fden_q   <= 31'd1;
			end
			fra_pkg::ST_MUL0: p0_q <= mul_p;
			fra_pkg::ST_MUL1: p1_q <= mul_p;
			fra_pkg::ST_MUL2: p2_q <= mul_p;
			fra_pkg::ST_COMB: begin
				mag_top_q <= abs_top[31:0];
				mag_bot_q <= abs_bot[30:0];
				neg_q     <= (top_c != 33'sd0) && (top_c[32] ^ bot_c[31]);
			end
			fra_pkg::ST_WHOLE: begin
				if (div_rsp.done) begin
					whole_q <= div_rsp.quotient;
					frem_q  <= t_c;
					y_q     <= t_c;
				end
			end
			fra_pkg::ST_GCD: begin
				if (div_rsp.done) begin
					y_q <= t_c;
					if (t_c == 31'd0) begin
						g_q <= y_q;
					end
				end
			end
			fra_pkg::ST_NUM: begin
				if (div_rsp.done) begin
					fnum_q <= div_rsp.quotient[29:0];
				end
			end
			fra_pkg::ST_DEN: begin
				if (div_rsp.done) begin
					fden_q <= div_rsp.quotient[30:0];
				end
			end
			default: begin
			end
		endcase
	end

	// Handshakes and packed result.
	assign s_axis_tready = (state_q == fra_pkg::ST_IDLE);
	assign m_axis_tvalid = (state_q == fra_pkg::ST_DONE);
	assign m_axis_tdata  = {2'b00, fden_q, fnum_q, whole_q, neg_q};
	assign m_axis_tuser  = status_q;

endmodule

`default_nettype wire

// File: sv/fra_checker.sv
// ----------------------------------------------------------------------------
// Fraction arithmetic port checker
// Watches the top-level ports and is bound to every instance of the block.
// ----------------------------------------------------------------------------
`default_nettype none

module fra_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_axis_tvalid,
	input wire        s_axis_tready,
	input wire [63:0] s_axis_tdata,
	input wire [1:0]  s_axis_tuser,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready,
	input wire [95:0] m_axis_tdata,
	input wire [1:0]  m_axis_tuser
);

	// A stalled result beat holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser))
		else $error("result beat changed while stalled");

	// One item at a time: no input while a result is pending.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input ready while result pending");

	// After an accepted input the block is busy.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input ready right after accept");

	// A result never carries a zero denominator or an unknown status.
	a_result_sane: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[93:63] != 31'd0)
		&& (m_axis_tuser == fra_pkg::STATUS_OK || m_axis_tuser == fra_pkg::STATUS_ZERO_DEN
		|| m_axis_tuser == fra_pkg::STATUS_DIV_ZERO))
		else $error("malformed result beat");

endmodule

bind fraction_arith_reduce fra_checker u_fra_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
